@@ hw/rtl/pes_pkg.sv @@
// Shared types, constants and fixed-point helpers for the particle Euler step block.
// No dependencies; every other file in hw/rtl imports this package.
package pes_pkg;

    localparam int SLOT_W      = 6;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Command codes
    localparam logic [2:0] CMD_LOAD     = 3'd0;
    localparam logic [2:0] CMD_FORCE1   = 3'd1;
    localparam logic [2:0] CMD_FORCEALL = 3'd2;
    localparam logic [2:0] CMD_STEP     = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE = 1'b1;

    localparam logic [15:0] DRAG_RST = 16'd60948;
    localparam logic [15:0] LIFE_RST = 16'd100;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [5:0]         slot;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_vx;
        logic signed [31:0] in_vy;
        logic signed [31:0] in_vz;
        logic [23:0]        in_inv_mass;
        logic               in_enabled;
        logic [15:0]        dt;
    } t_req;

    typedef struct packed {
        logic [5:0]         out_slot;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_vx;
        logic signed [31:0] out_vy;
        logic signed [31:0] out_vz;
        logic [15:0]        out_age;
        logic [31:0]        age_ratio;
        logic               out_enabled;
        logic               last;
    } t_res;

    // One particle as held in the store
    typedef struct packed {
        logic signed [31:0] p_x;
        logic signed [31:0] p_y;
        logic signed [31:0] p_z;
        logic signed [31:0] v_x;
        logic signed [31:0] v_y;
        logic signed [31:0] v_z;
        logic signed [31:0] f_x;
        logic signed [31:0] f_y;
        logic signed [31:0] f_z;
        logic [23:0]        recip_mass;
        logic [15:0]        age;
        logic               en;
    } t_word;

    typedef enum logic [1:0] {
        WS_CLEAR,
        WS_LOAD,
        WS_WORK
    } t_wsel;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LAT,
        OP_LATINC,
        OP_FADD,
        OP_MFM,
        OP_MDT,
        OP_ADDV,
        OP_ADDP,
        OP_DRAG
    } t_op;

    typedef enum logic [1:0] {
        M_FORCE1,
        M_FORCEALL,
        M_STEP,
        M_READ
    } t_mode;

    typedef struct packed {
        logic  req_load;
        logic  mem_re;
        logic  mem_we;
        t_wsel wsel;
        t_op   op;
        logic  div_start;
        logic  pend_load;
        logic  out_load_pend;
        logic  out_load_work;
        logic  out_last;
    } t_dp_ctl;

    typedef struct packed {
        logic rd_en;
        logic div_done;
    } t_dp_sts;

    // Saturating signed 32-bit add
    function automatic logic signed [31:0] addsat(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    // floor((a * b) / 2^16), saturated to signed 32 bits
    function automatic logic signed [31:0] mulq(logic signed [31:0] a, logic [23:0] b);
        logic signed [56:0] prod;
        logic signed [40:0] sh;
        prod = 57'(a) * $signed({33'd0, b});
        sh   = prod[56:16];
        if (sh > 41'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (sh < -41'sd2147483648) begin
            return 32'sh80000000;
        end
        return sh[31:0];
    endfunction

endpackage

@@ hw/rtl/pes_div.sv @@
// Age ratio divider: floor(age * 2^16 / lifetime), four quotient bits per cycle.
// Depends on pes_pkg. A zero lifetime gives all ones, as restoring division does.
module pes_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_age,
    input  logic [15:0] i_life,
    output logic [31:0] o_quo,
    output logic        o_done
);
    import pes_pkg::*;

    logic        r_busy, n_busy;
    logic [2:0]  r_cnt, n_cnt;
    logic [16:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [15:0] r_div;

    // Four restoring steps per cycle
    always_comb begin
        logic [16:0] rem;
        logic [31:0] quo;
        rem    = r_rem;
        quo    = r_quo;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (r_busy) begin
            for (int k = 0; k < 4; k++) begin
                rem = {rem[15:0], quo[31]};
                quo = {quo[30:0], 1'b0};
                if (rem >= {1'b0, r_div}) begin
                    rem    = rem - {1'b0, r_div};
                    quo[0] = 1'b1;
                end
            end
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
            end
        end
        n_rem = rem;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // Load numerator and divisor on start, then shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {i_age, 16'd0};
            r_div <= i_life;
        end else begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = !r_busy;

endmodule

@@ hw/rtl/pes_dp.sv @@
// Datapath: particle store memory, working particle, three multiply lanes,
// config registers, pending and output result registers. Depends on pes_pkg, pes_div.
module pes_dp #(
    parameter int NUM_PARTICLES = 64,
    parameter int AW            = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pes_pkg::t_req                      i_req,
    input  logic                               i_cfg_we,
    input  logic [pes_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pes_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  pes_pkg::t_dp_ctl                   i_ctl,
    input  logic [AW-1:0]                      i_addr,
    output pes_pkg::t_dp_sts                   o_sts,
    output pes_pkg::t_res                      o_res
);
    import pes_pkg::*;

    t_word       r_mem [NUM_PARTICLES];
    t_word       r_rdata;
    t_word       w_wdata;
    t_word       r_wk, n_wk;
    t_req        r_req;
    logic signed [31:0] r_acc_x, r_acc_y, r_acc_z;
    logic signed [31:0] n_acc_x, n_acc_y, n_acc_z;
    logic [5:0]  r_wslot, n_wslot;
    logic [15:0] r_drag, r_life;
    t_res        w_res, w_pend_out, r_pend, r_out;
    logic [31:0] w_quo;
    logic        w_done;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drag <= DRAG_RST;
            r_life <= LIFE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DRAG) begin
                r_drag <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_LIFE) begin
                r_life <= i_cfg_data;
            end
        end
    end

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (i_ctl.req_load) begin
            r_req <= i_req;
        end
    end

    // Select the store write word
    always_comb begin
        w_wdata = r_wk;
        unique case (i_ctl.wsel)
            WS_CLEAR: w_wdata = '0;
            WS_LOAD: begin
                w_wdata            = '0;
                w_wdata.p_x        = r_req.in_x;
                w_wdata.p_y        = r_req.in_y;
                w_wdata.p_z        = r_req.in_z;
                w_wdata.v_x        = r_req.in_vx;
                w_wdata.v_y        = r_req.in_vy;
                w_wdata.v_z        = r_req.in_vz;
                w_wdata.recip_mass = r_req.in_inv_mass;
                w_wdata.en         = r_req.in_enabled;
            end
            WS_WORK: w_wdata = r_wk;
            default: w_wdata = r_wk;
        endcase
    end

    // Particle store, one port each way
    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_we) begin
            r_mem[i_addr] <= w_wdata;
        end
        if (i_ctl.mem_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    // Working particle arithmetic, one step per command
    always_comb begin
        n_wk    = r_wk;
        n_wslot = r_wslot;
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        n_acc_z = r_acc_z;
        unique case (i_ctl.op)
            OP_NONE: ;
            OP_LAT: begin
                n_wk    = r_rdata;
                n_wslot = SLOT_W'(i_addr);
            end
            OP_LATINC: begin
                n_wk = r_rdata;
                if (r_rdata.age != 16'hFFFF) begin
                    n_wk.age = r_rdata.age + 16'd1;
                end
                n_wslot = SLOT_W'(i_addr);
            end
            OP_FADD: begin
                n_wk.f_x = addsat(r_wk.f_x, r_req.in_x);
                n_wk.f_y = addsat(r_wk.f_y, r_req.in_y);
                n_wk.f_z = addsat(r_wk.f_z, r_req.in_z);
            end
            OP_MFM: begin
                n_acc_x = mulq(r_wk.f_x, r_wk.recip_mass);
                n_acc_y = mulq(r_wk.f_y, r_wk.recip_mass);
                n_acc_z = mulq(r_wk.f_z, r_wk.recip_mass);
            end
            OP_MDT: begin
                n_acc_x = mulq(r_acc_x, {8'd0, r_req.dt});
                n_acc_y = mulq(r_acc_y, {8'd0, r_req.dt});
                n_acc_z = mulq(r_acc_z, {8'd0, r_req.dt});
            end
            OP_ADDV: begin
                n_wk.v_x = addsat(r_wk.v_x, r_acc_x);
                n_wk.v_y = addsat(r_wk.v_y, r_acc_y);
                n_wk.v_z = addsat(r_wk.v_z, r_acc_z);
            end
            OP_ADDP: begin
                n_wk.p_x = addsat(r_wk.p_x, r_wk.v_x);
                n_wk.p_y = addsat(r_wk.p_y, r_wk.v_y);
                n_wk.p_z = addsat(r_wk.p_z, r_wk.v_z);
            end
            OP_DRAG: begin
                n_wk.v_x = mulq(r_wk.v_x, {8'd0, r_drag});
                n_wk.v_y = mulq(r_wk.v_y, {8'd0, r_drag});
                n_wk.v_z = mulq(r_wk.v_z, {8'd0, r_drag});
                n_wk.f_x = '0;
                n_wk.f_y = '0;
                n_wk.f_z = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wk    <= n_wk;
        r_wslot <= n_wslot;
        r_acc_x <= n_acc_x;
        r_acc_y <= n_acc_y;
        r_acc_z <= n_acc_z;
    end

    pes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_age   (r_wk.age),
        .i_life  (r_life),
        .o_quo   (w_quo),
        .o_done  (w_done)
    );

    // Assemble a result from the working particle
    always_comb begin
        w_res.out_slot    = r_wslot;
        w_res.out_x       = r_wk.p_x;
        w_res.out_y       = r_wk.p_y;
        w_res.out_z       = r_wk.p_z;
        w_res.out_vx      = r_wk.v_x;
        w_res.out_vy      = r_wk.v_y;
        w_res.out_vz      = r_wk.v_z;
        w_res.out_age     = r_wk.age;
        w_res.age_ratio   = w_quo;
        w_res.out_enabled = r_wk.en;
        w_res.last        = i_ctl.out_last;
    end

    // Tag the pending result with the last mark on its way out
    always_comb begin
        w_pend_out      = r_pend;
        w_pend_out.last = i_ctl.out_last;
    end

    // Pending and output result registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.pend_load) begin
            r_pend <= w_res;
        end
        if (i_ctl.out_load_pend) begin
            r_out <= w_pend_out;
        end else if (i_ctl.out_load_work) begin
            r_out <= w_res;
        end
    end

    assign o_sts.rd_en    = r_rdata.en;
    assign o_sts.div_done = w_done;
    assign o_res          = r_out;

endmodule

@@ hw/rtl/pes_ctrl.sv @@
// Controller: command sequencer, store address walk, result count and handshakes.
// Depends on pes_pkg; drives pes_dp through t_dp_ctl.
module pes_ctrl #(
    parameter int NUM_PARTICLES = 64,
    parameter int AW            = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  logic [2:0]                i_cmd,
    input  logic [pes_pkg::SLOT_W-1:0] i_slot,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output pes_pkg::t_dp_ctl          o_ctl,
    output logic [AW-1:0]             o_addr,
    input  pes_pkg::t_dp_sts          i_sts
);
    import pes_pkg::*;

    typedef enum logic [18:0] {
        S_CLEAR  = 19'(1) << 0,
        S_IDLE   = 19'(1) << 1,
        S_LOADWR = 19'(1) << 2,
        S_RD     = 19'(1) << 3,
        S_LAT    = 19'(1) << 4,
        S_FADD   = 19'(1) << 5,
        S_WR     = 19'(1) << 6,
        S_MFM    = 19'(1) << 7,
        S_MDT1   = 19'(1) << 8,
        S_MDT2   = 19'(1) << 9,
        S_ADDV   = 19'(1) << 10,
        S_ADDP   = 19'(1) << 11,
        S_DRAG   = 19'(1) << 12,
        S_SWR    = 19'(1) << 13,
        S_SPUSH  = 19'(1) << 14,
        S_NEXT   = 19'(1) << 15,
        S_FLUSH  = 19'(1) << 16,
        S_RDIV   = 19'(1) << 17,
        S_RWAIT  = 19'(1) << 18
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pend_valid, n_pend_valid;
    logic             r_out_valid, n_out_valid;
    logic             w_acc, w_in_rng, w_last_addr, w_out_free;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_acc       = i_req_valid && o_req_ready;
    assign w_in_rng    = (32'(i_slot) < NUM_PARTICLES);
    assign w_last_addr = (r_addr == AW'(NUM_PARTICLES - 1));
    assign w_out_free  = !r_out_valid || i_res_ready;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_mode       = r_mode;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid;
        o_ctl        = '0;
        o_ctl.wsel   = WS_WORK;
        o_ctl.op     = OP_NONE;
        // Drop the output request once taken
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            // Sweep the store after reset, disabling every particle
            S_CLEAR: begin
                o_ctl.mem_we = 1'b1;
                o_ctl.wsel   = WS_CLEAR;
                if (w_last_addr) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            // Decode a new request
            S_IDLE: begin
                if (w_acc) begin
                    o_ctl.req_load = 1'b1;
                    if (i_cmd == CMD_LOAD && w_in_rng) begin
                        n_addr  = AW'(i_slot);
                        n_state = S_LOADWR;
                    end else if (i_cmd == CMD_FORCE1 && w_in_rng) begin
                        n_addr  = AW'(i_slot);
                        n_mode  = M_FORCE1;
                        n_state = S_RD;
                    end else if (i_cmd == CMD_READ && w_in_rng) begin
                        n_addr  = AW'(i_slot);
                        n_mode  = M_READ;
                        n_state = S_RD;
                    end else if (i_cmd == CMD_FORCEALL) begin
                        n_addr  = '0;
                        n_mode  = M_FORCEALL;
                        n_state = S_RD;
                    end else if (i_cmd == CMD_STEP) begin
                        n_addr  = '0;
                        n_cnt   = '0;
                        n_mode  = M_STEP;
                        n_state = S_RD;
                    end
                end
            end
            S_LOADWR: begin
                o_ctl.mem_we = 1'b1;
                o_ctl.wsel   = WS_LOAD;
                n_state      = S_IDLE;
            end
            S_RD: begin
                o_ctl.mem_re = 1'b1;
                n_state      = S_LAT;
            end
            // Latch the particle and branch on the command
            S_LAT: begin
                o_ctl.op = (r_mode == M_STEP) ? OP_LATINC : OP_LAT;
                unique case (r_mode)
                    M_FORCE1, M_FORCEALL: n_state = S_FADD;
                    M_READ:               n_state = S_RDIV;
                    M_STEP:               n_state = i_sts.rd_en ? S_MFM : S_NEXT;
                    default:              n_state = S_IDLE;
                endcase
            end
            S_FADD: begin
                o_ctl.op = OP_FADD;
                n_state  = S_WR;
            end
            S_WR: begin
                o_ctl.mem_we = 1'b1;
                n_state      = (r_mode == M_FORCEALL) ? S_NEXT : S_IDLE;
            end
            S_MFM: begin
                o_ctl.op        = OP_MFM;
                o_ctl.div_start = 1'b1;
                n_state         = S_MDT1;
            end
            S_MDT1: begin
                o_ctl.op = OP_MDT;
                n_state  = S_MDT2;
            end
            S_MDT2: begin
                o_ctl.op = OP_MDT;
                n_state  = S_ADDV;
            end
            S_ADDV: begin
                o_ctl.op = OP_ADDV;
                n_state  = S_ADDP;
            end
            S_ADDP: begin
                o_ctl.op = OP_ADDP;
                n_state  = S_DRAG;
            end
            S_DRAG: begin
                o_ctl.op = OP_DRAG;
                n_state  = S_SWR;
            end
            S_SWR: begin
                o_ctl.mem_we = 1'b1;
                n_state      = S_SPUSH;
            end
            // Hold one result back so the final one can carry last
            S_SPUSH: begin
                if (i_sts.div_done) begin
                    if (r_cnt == CNT_W'(MAX_RESULTS)) begin
                        n_state = S_NEXT;
                    end else if (!r_pend_valid) begin
                        o_ctl.pend_load = 1'b1;
                        n_pend_valid    = 1'b1;
                        n_cnt           = r_cnt + CNT_W'(1);
                        n_state         = S_NEXT;
                    end else if (w_out_free) begin
                        o_ctl.out_load_pend = 1'b1;
                        o_ctl.pend_load     = 1'b1;
                        n_out_valid         = 1'b1;
                        n_cnt               = r_cnt + CNT_W'(1);
                        n_state             = S_NEXT;
                    end
                end
            end
            // Advance the walk
            S_NEXT: begin
                if (w_last_addr) begin
                    n_addr  = '0;
                    n_state = (r_mode == M_STEP) ? S_FLUSH : S_IDLE;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_RD;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    o_ctl.out_load_pend = 1'b1;
                    o_ctl.out_last      = 1'b1;
                    n_out_valid         = 1'b1;
                    n_pend_valid        = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            S_RDIV: begin
                o_ctl.div_start = 1'b1;
                n_state         = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_sts.div_done && w_out_free) begin
                    o_ctl.out_load_work = 1'b1;
                    o_ctl.out_last      = 1'b1;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_mode       <= M_FORCE1;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_mode       <= n_mode;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_addr      = r_addr;
    assign o_res_valid = r_out_valid;

endmodule

@@ hw/rtl/particle_euler_step.sv @@
// Top level of the particle Euler step block: controller plus datapath.
// Depends on pes_pkg, pes_ctrl, pes_dp, pes_div.
//
//   channel   signals                            width
//   request   i_req_valid / o_req_ready / i_req  t_req
//   result    o_res_valid / i_res_ready / o_res  t_res
//   config    i_cfg_we / i_cfg_idx / i_cfg_data  1 / 16 bits
//
// Load writes the slot; force one and force all read, add the force and
// write back; read waits for the age ratio divider. Step skips disabled
// particles and runs enabled ones through the multiply lanes and divider.
// After reset a clearing pass writes every store slot before requests are taken.
// A stalled result holds the step walk only when a new result must be pushed.
module particle_euler_step #(
    parameter int NUM_PARTICLES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    output logic                               o_req_ready,
    input  pes_pkg::t_req                      i_req,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output pes_pkg::t_res                      o_res,
    input  logic                               i_cfg_we,
    input  logic [pes_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pes_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pes_pkg::*;

    localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

    t_dp_ctl       w_ctl;
    t_dp_sts       w_sts;
    logic [AW-1:0] w_addr;

    pes_ctrl #(
        .NUM_PARTICLES (NUM_PARTICLES),
        .AW            (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_cmd       (i_req.cmd),
        .i_slot      (i_req.slot),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_ctl       (w_ctl),
        .o_addr      (w_addr),
        .i_sts       (w_sts)
    );

    pes_dp #(
        .NUM_PARTICLES (NUM_PARTICLES),
        .AW            (AW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (w_ctl),
        .i_addr     (w_addr),
        .o_sts      (w_sts),
        .o_res      (o_res)
    );

endmodule

@@ hw/rtl/pes_checker.sv @@
// Port-level checker for particle_euler_step, attached by bind.
// Depends on pes_pkg.
module pes_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           o_req_ready,
    input pes_pkg::t_req                  i_req,
    input logic                           o_res_valid,
    input logic                           i_res_ready,
    input pes_pkg::t_res                  o_res,
    input logic                           i_cfg_we,
    input logic [pes_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [pes_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pes_pkg::*;

    // Hold a stalled result request
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

    // An accepted step keeps the request side busy in the cycle after it
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready && i_req.cmd == CMD_STEP |=> !o_req_ready)
        else $error("step did not hold off requests");

    // Results only come up out of a busy cycle
    a_res_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> !$past(o_req_ready))
        else $error("result raised while idle");

    // No result right out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_res_valid)
        else $error("result valid after reset");

    // Write config only while idle with no result waiting
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_req_ready && !o_res_valid && !$isunknown({i_cfg_idx, i_cfg_data}))
        else $error("config written while busy");

endmodule

bind particle_euler_step pes_checker u_pes_checker (.*);
